/* sv/hpt_pkg.sv */
// Shared types and constants for the handle pool tracker.
`default_nettype none

package hpt_pkg;

    localparam int SLOTS       = 32;
    localparam int HANDLE_BITS = 16;
    localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W       = $clog2(SLOTS + 1);
    localparam int POOL_W      = 6;
    localparam int IO_HANDLE_W = 16;
    localparam int IO_SLOT_W   = 5;
    localparam int IO_CNT_W    = 6;
    localparam int IO_CMD_W    = 3;
    localparam int IO_STAT_W   = 2;

    localparam logic [POOL_W-1:0] POOL_RESET = POOL_W'(32);

    typedef logic [HANDLE_BITS-1:0] handle_t;
    typedef logic [SLOT_W-1:0]      slot_t;
    typedef logic [CNT_W-1:0]       cnt_t;
    typedef logic [SLOTS-1:0]       slot_vec_t;

    typedef enum logic [IO_CMD_W-1:0] {
        CMD_TAKE_ANY   = 3'd0,
        CMD_PUT        = 3'd1,
        CMD_REMOVE     = 3'd2,
        CMD_TAKE_INDEX = 3'd3,
        CMD_PUT_INDEX  = 3'd4,
        CMD_CLEAR      = 3'd5
    } cmd_t;

    typedef enum logic [IO_STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_UNAVAIL = 2'd1,
        ST_FULL    = 2'd2,
        ST_BADARG  = 2'd3
    } status_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } ctrl_t;

    // datapath -> controller
    typedef struct packed {
        logic out_room;
    } stat_t;

endpackage

`default_nettype wire

/* sv/hpt_req_if.sv */
// Request channel: valid/ready handshake with command payload.
`default_nettype none

interface hpt_req_if;
    logic                          valid;
    logic                          ready;
    logic [hpt_pkg::IO_CMD_W-1:0]    command;
    logic [hpt_pkg::IO_HANDLE_W-1:0] handle;
    logic [hpt_pkg::IO_SLOT_W-1:0]   slot_index;

    modport source (output valid, output command, output handle, output slot_index,
                    input ready);
    modport sink   (input valid, input command, input handle, input slot_index,
                    output ready);
endinterface

`default_nettype wire

/* sv/hpt_rsp_if.sv */
// Response channel: valid/ready handshake with result payload.
`default_nettype none

interface hpt_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [hpt_pkg::IO_STAT_W-1:0]   status;
    logic [hpt_pkg::IO_HANDLE_W-1:0] handle_out;
    logic [hpt_pkg::IO_SLOT_W-1:0]   slot_out;
    logic [hpt_pkg::IO_CNT_W-1:0]    occupied;

    modport source (output valid, output status, output handle_out, output slot_out,
                    output occupied, input ready);
    modport sink   (input valid, input status, input handle_out, input slot_out,
                    input occupied, output ready);
endinterface

`default_nettype wire

/* sv/hpt_ctrl.sv */
// Controller state machine: accept, scan, commit sequencing.
`default_nettype none

module hpt_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_ready,
    input  wire hpt_pkg::stat_t stat,
    output hpt_pkg::ctrl_t      ctrl
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_COMMIT = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   commit_ok;
    logic   accept;

    assign commit_ok = (state_reg == S_COMMIT) && stat.out_room;
    assign req_ready = (state_reg == S_IDLE) || commit_ok;
    assign accept    = req_valid && req_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (stat.out_room)
                begin
                    state_next = accept ? S_SCAN : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign ctrl.load   = accept;
    assign ctrl.scan   = (state_reg == S_SCAN);
    assign ctrl.commit = commit_ok;

    a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_SCAN)
        else $error("accepted request did not enter scan");

    a_scan_commit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |=> state_reg == S_COMMIT)
        else $error("scan not followed by commit");

endmodule

`default_nettype wire

/* sv/hpt_dpath.sv */
// Datapath: slot store, parallel lookup, update and result register.
`default_nettype none

module hpt_dpath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire hpt_pkg::ctrl_t                    ctrl,
    output hpt_pkg::stat_t                         stat,
    input  wire logic                              cfg_we,
    input  wire logic [hpt_pkg::POOL_W-1:0]        cfg_wdata,
    input  wire logic [hpt_pkg::IO_CMD_W-1:0]      req_command,
    input  wire logic [hpt_pkg::IO_HANDLE_W-1:0]   req_handle,
    input  wire logic [hpt_pkg::IO_SLOT_W-1:0]     req_slot_index,
    output logic                                   rsp_valid,
    input  wire logic                              rsp_ready,
    output logic [hpt_pkg::IO_STAT_W-1:0]          rsp_status,
    output logic [hpt_pkg::IO_HANDLE_W-1:0]        rsp_handle_out,
    output logic [hpt_pkg::IO_SLOT_W-1:0]          rsp_slot_out,
    output logic [hpt_pkg::IO_CNT_W-1:0]           rsp_occupied
);

    function automatic hpt_pkg::slot_t lowest(input hpt_pkg::slot_vec_t v);
        hpt_pkg::slot_t r;
        r = '0;
        for (int i = hpt_pkg::SLOTS - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = hpt_pkg::slot_t'(i);
            end
        end
        return r;
    endfunction

    // configuration
    logic [hpt_pkg::POOL_W-1:0] pool_size_reg;
    logic [hpt_pkg::POOL_W-1:0] size_eff;

    // request
    hpt_pkg::cmd_t                    cmd_reg;
    hpt_pkg::handle_t                 hnd_reg;
    logic [hpt_pkg::IO_SLOT_W-1:0]    idx_reg;
    hpt_pkg::slot_t                   idx_slot;

    // slot state
    hpt_pkg::handle_t   slot_handle_mem [hpt_pkg::SLOTS];
    hpt_pkg::slot_vec_t used_reg;
    hpt_pkg::slot_vec_t used_next;
    hpt_pkg::slot_vec_t free_reg;
    hpt_pkg::slot_vec_t free_next;
    hpt_pkg::cnt_t      count_reg;
    hpt_pkg::cnt_t      count_next;

    // scan results
    hpt_pkg::slot_vec_t in_pool;
    hpt_pkg::slot_vec_t hit_vec;
    hpt_pkg::slot_vec_t avail_vec;
    hpt_pkg::slot_vec_t vac_vec;
    hpt_pkg::slot_vec_t hit_reg;
    logic               hit_any_reg;
    hpt_pkg::slot_t     hit_slot_reg;
    logic               avail_any_reg;
    hpt_pkg::slot_t     avail_slot_reg;
    logic               vac_any_reg;
    hpt_pkg::slot_t     vac_slot_reg;
    logic               idx_bad_reg;

    // commit
    hpt_pkg::slot_t     rd_addr;
    hpt_pkg::handle_t   rd_data;
    logic               wr_en;
    hpt_pkg::slot_t     wr_addr;
    hpt_pkg::status_t   res_status;
    hpt_pkg::handle_t   res_handle;
    hpt_pkg::slot_t     res_slot;

    // result register
    logic                                 out_valid_reg;
    logic                                 out_valid_next;
    logic [hpt_pkg::IO_STAT_W-1:0]        out_status_reg;
    logic [hpt_pkg::IO_HANDLE_W-1:0]      out_handle_reg;
    logic [hpt_pkg::IO_SLOT_W-1:0]        out_slot_reg;
    logic [hpt_pkg::IO_CNT_W-1:0]         out_occ_reg;

    assign size_eff = (pool_size_reg > hpt_pkg::POOL_W'(hpt_pkg::SLOTS)) ?
                      hpt_pkg::POOL_W'(hpt_pkg::SLOTS) : pool_size_reg;
    assign idx_slot = idx_reg[hpt_pkg::SLOT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_size_reg <= hpt_pkg::POOL_RESET;
        end
        else if (cfg_we)
        begin
            pool_size_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cmd_reg <= hpt_pkg::cmd_t'(req_command);
            hnd_reg <= hpt_pkg::handle_t'(req_handle);
            idx_reg <= req_slot_index;
        end
    end

    // parallel lookup over all slots
    always_comb
    begin
        for (int i = 0; i < hpt_pkg::SLOTS; i++)
        begin
            in_pool[i]   = size_eff > hpt_pkg::POOL_W'(i);
            hit_vec[i]   = in_pool[i] && used_reg[i] && (slot_handle_mem[i] == hnd_reg);
            avail_vec[i] = in_pool[i] && used_reg[i] && free_reg[i];
            vac_vec[i]   = in_pool[i] && !used_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.scan)
        begin
            hit_reg        <= hit_vec;
            hit_any_reg    <= |hit_vec;
            hit_slot_reg   <= lowest(hit_vec);
            avail_any_reg  <= |avail_vec;
            avail_slot_reg <= lowest(avail_vec);
            vac_any_reg    <= |vac_vec;
            vac_slot_reg   <= lowest(vac_vec);
            idx_bad_reg    <= {1'b0, idx_reg} >= size_eff;
        end
    end

    assign rd_addr = (cmd_reg == hpt_pkg::CMD_TAKE_ANY) ? avail_slot_reg : idx_slot;
    assign rd_data = slot_handle_mem[rd_addr];

    always_comb
    begin
        used_next  = used_reg;
        free_next  = free_reg;
        count_next = count_reg;
        wr_en      = 1'b0;
        wr_addr    = idx_slot;
        res_status = hpt_pkg::ST_OK;
        res_handle = '0;
        res_slot   = '0;
        if (ctrl.commit)
        begin
            unique case (cmd_reg)
                hpt_pkg::CMD_TAKE_ANY:
                begin
                    if (avail_any_reg)
                    begin
                        free_next[avail_slot_reg] = 1'b0;
                        res_handle = rd_data;
                        res_slot   = avail_slot_reg;
                    end
                    else
                    begin
                        res_status = hpt_pkg::ST_UNAVAIL;
                    end
                end
                hpt_pkg::CMD_PUT:
                begin
                    if (hit_any_reg)
                    begin
                        free_next[hit_slot_reg] = 1'b1;
                        res_handle = hnd_reg;
                        res_slot   = hit_slot_reg;
                    end
                    else if (vac_any_reg)
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = vac_slot_reg;
                        used_next[vac_slot_reg] = 1'b1;
                        free_next[vac_slot_reg] = 1'b1;
                        count_next = count_reg + hpt_pkg::cnt_t'(1);
                        res_handle = hnd_reg;
                        res_slot   = vac_slot_reg;
                    end
                    else
                    begin
                        res_status = hpt_pkg::ST_FULL;
                    end
                end
                hpt_pkg::CMD_REMOVE:
                begin
                    used_next  = used_reg & ~hit_reg;
                    free_next  = free_reg & ~hit_reg;
                    count_next = count_reg - hpt_pkg::cnt_t'($countones(hit_reg));
                    res_slot   = hit_any_reg ? hit_slot_reg : '0;
                end
                hpt_pkg::CMD_TAKE_INDEX:
                begin
                    if (idx_bad_reg)
                    begin
                        res_status = hpt_pkg::ST_BADARG;
                    end
                    else if (!used_reg[idx_slot] || !free_reg[idx_slot])
                    begin
                        res_status = hpt_pkg::ST_UNAVAIL;
                    end
                    else
                    begin
                        free_next[idx_slot] = 1'b0;
                        res_handle = rd_data;
                        res_slot   = idx_slot;
                    end
                end
                hpt_pkg::CMD_PUT_INDEX:
                begin
                    if (idx_bad_reg)
                    begin
                        res_status = hpt_pkg::ST_BADARG;
                    end
                    else if (free_reg[idx_slot])
                    begin
                        res_status = hpt_pkg::ST_FULL;
                    end
                    else
                    begin
                        free_next[idx_slot] = 1'b1;
                        if (!used_reg[idx_slot])
                        begin
                            wr_en      = 1'b1;
                            used_next[idx_slot] = 1'b1;
                            count_next = count_reg + hpt_pkg::cnt_t'(1);
                        end
                        res_handle = hnd_reg;
                        res_slot   = idx_slot;
                    end
                end
                hpt_pkg::CMD_CLEAR:
                begin
                    used_next  = '0;
                    free_next  = '0;
                    count_next = '0;
                end
                default:
                begin
                    res_status = hpt_pkg::ST_BADARG;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_handle_mem[wr_addr] <= hnd_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg  <= '0;
            free_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            used_reg  <= used_next;
            free_reg  <= free_next;
            count_reg <= count_next;
        end
    end

    // result register
    assign stat.out_room = !out_valid_reg || rsp_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctrl.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.commit)
        begin
            out_status_reg <= res_status;
            out_handle_reg <= hpt_pkg::IO_HANDLE_W'(res_handle);
            out_slot_reg   <= hpt_pkg::IO_SLOT_W'(res_slot);
            out_occ_reg    <= hpt_pkg::IO_CNT_W'(count_next);
        end
    end

    assign rsp_valid      = out_valid_reg;
    assign rsp_status     = out_status_reg;
    assign rsp_handle_out = out_handle_reg;
    assign rsp_slot_out   = out_slot_reg;
    assign rsp_occupied   = out_occ_reg;

    a_count_tracks_used: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == hpt_pkg::cnt_t'($countones(used_reg)))
        else $error("occupancy count out of step with used marks");

    a_free_implies_used: assert property (@(posedge clk) disable iff (!rst_n)
        (free_reg & ~used_reg) == '0)
        else $error("free mark on an empty slot");

    a_commit_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.commit |=> out_valid_reg)
        else $error("commit did not present a result");

endmodule

`default_nettype wire

/* sv/handle_pool_tracker_core.sv */
// Top level of the handle pool tracker: controller plus datapath.
// Sequence: an accepted request is registered, looked up in the scan state and
// applied in the commit state, which waits for room in the result register.
// Lookup and update share the slot state; the next request is taken on commit.
// Reset: used and free marks, occupancy count and result valid clear; pool
// size returns to 32. Stored handles are not reset; no clearing pass.
`default_nettype none

module handle_pool_tracker_core (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [hpt_pkg::POOL_W-1:0] cfg_wdata,
    hpt_req_if.sink                         req,
    hpt_rsp_if.source                       rsp
);

    hpt_pkg::ctrl_t ctrl;
    hpt_pkg::stat_t stat;

    hpt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    hpt_dpath u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (ctrl),
        .stat           (stat),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .req_command    (req.command),
        .req_handle     (req.handle),
        .req_slot_index (req.slot_index),
        .rsp_valid      (rsp.valid),
        .rsp_ready      (rsp.ready),
        .rsp_status     (rsp.status),
        .rsp_handle_out (rsp.handle_out),
        .rsp_slot_out   (rsp.slot_out),
        .rsp_occupied   (rsp.occupied)
    );

endmodule

`default_nettype wire

/* dv/handle_pool_tracker_core_test.sv */
`timescale 1ns / 100ps
// Self-checking testbench for handle_pool_tracker_core: random pool traffic against a predictor.

module handle_pool_tracker_core_test;
    import hpt_pkg::*;

    localparam logic [IO_CMD_W-1:0] CMD_UNKNOWN_LO = 3'd6;
    localparam logic [IO_CMD_W-1:0] CMD_UNKNOWN_HI = 3'd7;
    localparam int CYCLE_LIMIT = 400000;
    localparam int REPORT_CAP  = 40;

    typedef struct packed {
        logic [IO_CMD_W-1:0]    command;
        logic [IO_HANDLE_W-1:0] handle;
        logic [IO_SLOT_W-1:0]   slot_index;
    } pool_request_t;

    typedef struct packed {
        status_t                status;
        logic [IO_HANDLE_W-1:0] handle_out;
        logic [IO_SLOT_W-1:0]   slot_out;
        logic [IO_CNT_W-1:0]    occupied;
    } pool_reply_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_we;
    logic [POOL_W-1:0] cfg_wdata;

    hpt_req_if req_ch();
    hpt_rsp_if rsp_ch();

    handle_pool_tracker_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // predicted pool contents
    handle_t           pool_handle [SLOTS];
    logic              pool_used [SLOTS];
    logic              pool_free [SLOTS];
    logic [IO_CNT_W-1:0] pool_count;
    logic [POOL_W-1:0] pool_size_reg;

    pool_request_t pending_requests [$];
    pool_reply_t   awaited_replies [$];

    bit            sender_idles;
    bit            receiver_idles;
    int            send_gap;
    int            stall_left;
    int            mismatches = 0;
    int            cycle_count = 0;
    pool_request_t next_req;
    pool_request_t seen_req;
    pool_reply_t   want;

    function automatic int live_slots();
        return (pool_size_reg > SLOTS) ? SLOTS : int'(pool_size_reg);
    endfunction

    function automatic pool_reply_t predict_reply(pool_request_t rq);
        pool_reply_t rp;
        int          size;
        int          vacant;
        int          match;
        bit          hit;
        size          = live_slots();
        rp.status     = ST_OK;
        rp.handle_out = '0;
        rp.slot_out   = '0;
        hit           = 1'b0;
        case (rq.command)
            CMD_TAKE_ANY:
            begin
                rp.status = ST_UNAVAIL;
                for (int i = 0; i < size; i++)
                begin
                    if (rp.status == ST_UNAVAIL && pool_used[i] && pool_free[i])
                    begin
                        pool_free[i]  = 1'b0;
                        rp.status     = ST_OK;
                        rp.handle_out = pool_handle[i];
                        rp.slot_out   = IO_SLOT_W'(i);
                    end
                end
            end
            CMD_PUT:
            begin
                vacant = size;
                match  = size;
                for (int i = 0; i < size; i++)
                begin
                    if (vacant == size && !pool_used[i])
                        vacant = i;
                    if (match == size && pool_used[i] && pool_handle[i] == rq.handle)
                        match = i;
                end
                if (match < size)
                begin
                    pool_free[match] = 1'b1;
                    rp.handle_out    = rq.handle;
                    rp.slot_out      = IO_SLOT_W'(match);
                end
                else if (vacant < size)
                begin
                    pool_handle[vacant] = rq.handle;
                    pool_used[vacant]   = 1'b1;
                    pool_free[vacant]   = 1'b1;
                    pool_count++;
                    rp.handle_out       = rq.handle;
                    rp.slot_out         = IO_SLOT_W'(vacant);
                end
                else
                    rp.status = ST_FULL;
            end
            CMD_REMOVE:
            begin
                for (int i = 0; i < size; i++)
                begin
                    if (pool_used[i] && pool_handle[i] == rq.handle)
                    begin
                        if (!hit)
                            rp.slot_out = IO_SLOT_W'(i);
                        hit          = 1'b1;
                        pool_used[i] = 1'b0;
                        pool_free[i] = 1'b0;
                        if (pool_count != 0)
                            pool_count--;
                    end
                end
            end
            CMD_TAKE_INDEX:
            begin
                if (rq.slot_index >= size)
                    rp.status = ST_BADARG;
                else if (!pool_used[rq.slot_index] || !pool_free[rq.slot_index])
                    rp.status = ST_UNAVAIL;
                else
                begin
                    pool_free[rq.slot_index] = 1'b0;
                    rp.handle_out            = pool_handle[rq.slot_index];
                    rp.slot_out              = rq.slot_index;
                end
            end
            CMD_PUT_INDEX:
            begin
                if (rq.slot_index >= size)
                    rp.status = ST_BADARG;
                else if (pool_free[rq.slot_index])
                    rp.status = ST_FULL;
                else
                begin
                    pool_free[rq.slot_index] = 1'b1;
                    if (!pool_used[rq.slot_index])
                    begin
                        pool_handle[rq.slot_index] = rq.handle;
                        pool_used[rq.slot_index]   = 1'b1;
                        pool_count++;
                    end
                    rp.handle_out = rq.handle;
                    rp.slot_out   = rq.slot_index;
                end
            end
            CMD_CLEAR:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    pool_used[i] = 1'b0;
                    pool_free[i] = 1'b0;
                end
                pool_count = '0;
            end
            default:
                rp.status = ST_BADARG;
        endcase
        if (rp.status != ST_OK)
            rp.handle_out = '0;
        rp.occupied = pool_count;
        return rp;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= REPORT_CAP)
            $display("%0t ns mismatch: %s", $time, what);
    endtask

    task automatic queue_request(input logic [IO_CMD_W-1:0] command,
                                 input logic [IO_HANDLE_W-1:0] handle,
                                 input logic [IO_SLOT_W-1:0] slot_index);
        pool_request_t rq;
        rq.command    = command;
        rq.handle     = handle;
        rq.slot_index = slot_index;
        pending_requests.push_back(rq);
    endtask

    // mostly a small set of handles so lookups hit
    function automatic logic [IO_HANDLE_W-1:0] pick_handle();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 6)
            return 16'h5A30 + 16'($urandom_range(0, 11));
        if (roll == 6)
            return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
        return 16'($urandom);
    endfunction

    task automatic queue_random(input int count);
        int                   roll;
        int                   span;
        logic [IO_SLOT_W-1:0] idx;
        for (int n = 0; n < count; n++)
        begin
            span = live_slots();
            roll = $urandom_range(0, 99);
            if (span != 0 && $urandom_range(0, 7) != 0)
                idx = IO_SLOT_W'($urandom_range(0, span - 1));
            else
                idx = IO_SLOT_W'($urandom_range(0, 31));
            if (roll < 30)
                queue_request(CMD_PUT, pick_handle(), idx);
            else if (roll < 50)
                queue_request(CMD_TAKE_ANY, pick_handle(), idx);
            else if (roll < 65)
                queue_request(CMD_TAKE_INDEX, pick_handle(), idx);
            else if (roll < 80)
                queue_request(CMD_PUT_INDEX, pick_handle(), idx);
            else if (roll < 97)
                queue_request(CMD_REMOVE, pick_handle(), idx);
            else if (roll < 98)
                queue_request(CMD_CLEAR, pick_handle(), idx);
            else
                queue_request(($urandom_range(0, 1) != 0) ? CMD_UNKNOWN_HI : CMD_UNKNOWN_LO,
                              pick_handle(), idx);
        end
    endtask

    task automatic wait_drained();
        do
        begin
            @(negedge clk);
        end
        while (pending_requests.size() != 0 || req_ch.valid || awaited_replies.size() != 0);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_pool_size(input logic [POOL_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        pool_size_reg = value;
        @(negedge clk);
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            send_gap     <= 0;
        end
        else if (!req_ch.valid || req_ch.ready)
        begin
            if (send_gap != 0)
            begin
                send_gap     <= send_gap - 1;
                req_ch.valid <= 1'b0;
            end
            else if (sender_idles && pending_requests.size() != 0 && $urandom_range(0, 5) == 0)
            begin
                send_gap     <= $urandom_range(0, 10);
                req_ch.valid <= 1'b0;
            end
            else if (pending_requests.size() != 0)
            begin
                next_req = pending_requests.pop_front();
                req_ch.valid      <= 1'b1;
                req_ch.command    <= next_req.command;
                req_ch.handle     <= next_req.handle;
                req_ch.slot_index <= next_req.slot_index;
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    // reply backpressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            stall_left   <= 0;
        end
        else if (stall_left != 0)
        begin
            stall_left   <= stall_left - 1;
            rsp_ch.ready <= 1'b0;
        end
        else if (receiver_idles && $urandom_range(0, 5) == 0)
        begin
            stall_left   <= $urandom_range(0, 10);
            rsp_ch.ready <= 1'b0;
        end
        else
            rsp_ch.ready <= 1'b1;
    end

    // reply check, then predict the request taken on this edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (awaited_replies.size() == 0)
                    report_mismatch($sformatf("reply with none pending, status %0d slot %0d",
                                              rsp_ch.status, rsp_ch.slot_out));
                else
                begin
                    want = awaited_replies.pop_front();
                    if (rsp_ch.status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  rsp_ch.status, want.status));
                    if (rsp_ch.handle_out !== want.handle_out)
                        report_mismatch($sformatf("handle_out %h, expected %h",
                                                  rsp_ch.handle_out, want.handle_out));
                    if (rsp_ch.slot_out !== want.slot_out)
                        report_mismatch($sformatf("slot_out %0d, expected %0d",
                                                  rsp_ch.slot_out, want.slot_out));
                    if (rsp_ch.occupied !== want.occupied)
                        report_mismatch($sformatf("occupied %0d, expected %0d",
                                                  rsp_ch.occupied, want.occupied));
                end
            end
            if (req_ch.valid && req_ch.ready)
            begin
                seen_req.command    = req_ch.command;
                seen_req.handle     = req_ch.handle;
                seen_req.slot_index = req_ch.slot_index;
                awaited_replies.push_back(predict_reply(seen_req));
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    initial
    begin
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = '0;
        req_ch.valid      = 1'b0;
        req_ch.command    = '0;
        req_ch.handle     = '0;
        req_ch.slot_index = '0;
        rsp_ch.ready      = 1'b0;
        sender_idles      = 1'b1;
        receiver_idles    = 1'b1;
        pool_size_reg     = POOL_RESET;
        pool_count        = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            pool_used[i] = 1'b0;
            pool_free[i] = 1'b0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // full-size pool straight out of reset
        queue_request(CMD_TAKE_ANY, 16'h0000, 5'd0);
        queue_request(CMD_TAKE_INDEX, 16'h0000, 5'd0);
        queue_request(CMD_PUT_INDEX, 16'hFFFF, 5'd31);
        queue_request(CMD_PUT, 16'h0000, 5'd0);
        queue_request(CMD_PUT, 16'h0000, 5'd0);
        queue_request(CMD_TAKE_ANY, 16'h0000, 5'd0);
        queue_request(CMD_TAKE_INDEX, 16'h0000, 5'd0);
        queue_request(CMD_PUT_INDEX, 16'h1234, 5'd0);
        queue_request(CMD_PUT_INDEX, 16'h1234, 5'd0);
        queue_request(CMD_TAKE_INDEX, 16'h0000, 5'd31);
        queue_request(CMD_REMOVE, 16'h0000, 5'd0);
        queue_request(CMD_REMOVE, 16'hABCD, 5'd0);
        queue_request(CMD_PUT, 16'hABCD, 5'd0);
        queue_request(CMD_PUT_INDEX, 16'hABCD, 5'd7);
        queue_request(CMD_REMOVE, 16'hABCD, 5'd0);
        queue_request(CMD_UNKNOWN_HI, 16'hAAAA, 5'd28);
        queue_request(CMD_CLEAR, 16'h0000, 5'd0);
        wait_drained();

        // empty pool
        write_pool_size(6'd0);
        queue_request(CMD_TAKE_ANY, 16'h0000, 5'd0);
        queue_request(CMD_TAKE_INDEX, 16'h0000, 5'd0);
        queue_request(CMD_PUT_INDEX, 16'h7777, 5'd0);
        queue_request(CMD_PUT, 16'h7777, 5'd0);
        queue_request(CMD_REMOVE, 16'hFFFF, 5'd31);
        queue_request(CMD_CLEAR, 16'h0000, 5'd0);
        queue_random(20);
        wait_drained();

        // oversize setting clamps to the built slot count
        write_pool_size(6'd63);
        queue_request(CMD_PUT_INDEX, 16'h8001, 5'd31);
        queue_request(CMD_TAKE_INDEX, 16'h0000, 5'd31);
        queue_random(400);
        wait_drained();

        // shrunk pool keeps the upper slots counted
        write_pool_size(6'd5);
        queue_random(250);
        wait_drained();

        write_pool_size(6'd1);
        queue_random(150);
        wait_drained();

        write_pool_size(6'd17);
        queue_random(250);
        wait_drained();

        write_pool_size(6'd32);
        queue_random(250);
        wait_drained();

        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        queue_random(150);
        wait_drained();

        repeat (6) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* handle_pool_tracker_core.f */
sv/hpt_pkg.sv
sv/hpt_req_if.sv
sv/hpt_rsp_if.sv
sv/hpt_ctrl.sv
sv/hpt_dpath.sv
sv/handle_pool_tracker_core.sv
dv/handle_pool_tracker_core_test.sv
